// ===== src/mwo_pkg.sv =====
// Shared constants, types and the quarter-wave sine table of the oscillator core.
`timescale 1ns / 1ps

package mwo_pkg;

	localparam int PHASE_BITS  = 32;
	localparam int SAMPLE_BITS = 24;
	localparam int SINE_DEPTH  = 1024;
	localparam int SINE_IDX_W  = $clog2(SINE_DEPTH);
	localparam int SINE_ADDR_W = SINE_IDX_W + 1;
	localparam int SKEW_W      = 17;
	localparam int ONE_Q16     = 65536;
	localparam int DIV_STEPS   = PHASE_BITS - 16;
	localparam int DIV_CNT_W   = $clog2(DIV_STEPS);
	localparam int FACT_W      = 19;
	localparam int MCAND_W     = SAMPLE_BITS + 1;
	localparam int PROD_W      = FACT_W + MCAND_W;
	localparam int ACC_W       = PROD_W + 2;
	localparam longint PI_HALF_Q30 = 64'sd1686629713;

	typedef logic [PHASE_BITS-1:0]         phase_t;
	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic [SKEW_W-1:0]             wave_t;
	typedef logic [SINE_ADDR_W-1:0]        sine_addr_t;
	typedef logic [SINE_IDX_W-1:0]         sine_idx_t;
	typedef logic [DIV_STEPS-1:0]          div_lo_t;
	typedef logic [DIV_CNT_W-1:0]          div_cnt_t;
	typedef logic signed [FACT_W-1:0]      fact_t;
	typedef logic signed [MCAND_W-1:0]     mcand_t;
	typedef logic signed [PROD_W-1:0]      prod_t;
	typedef logic signed [ACC_W-1:0]       acc_t;

	localparam acc_t SAT_HI = acc_t'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
	localparam acc_t SAT_LO = acc_t'(-(64'sd1 <<< (SAMPLE_BITS - 1)));

	// Waveform codes; any code above square produces silence.
	localparam logic [1:0] WAVE_SINE     = 2'd0;
	localparam logic [1:0] WAVE_TRIANGLE = 2'd1;
	localparam logic [1:0] WAVE_SQUARE   = 2'd2;

	// Configuration register indexes.
	localparam logic [1:0] REG_WAVEFORM   = 2'd0;
	localparam logic [1:0] REG_SCALE_MODE = 2'd1;
	localparam logic [1:0] REG_BYPASS     = 2'd2;

	localparam logic MODE_OFFSET_SCALE = 1'b0;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROM,
		ST_DIV,
		ST_MUL,
		ST_ADD,
		ST_OUT
	} state_t;

	typedef wave_t sine_rom_t [0:SINE_DEPTH];

	// Restoring long division of a non-negative value, used only while the table is built.
	function automatic longint long_div(longint num, longint den);
		longint quo;
		longint rem;
		quo = 0;
		rem = 0;
		for (int i = 62; i >= 0; i--) begin
			rem = (rem <<< 1) | ((num >>> i) & 64'sd1);
			if (rem >= den) begin
				rem = rem - den;
				quo = quo | (64'sd1 <<< i);
			end
		end
		return quo;
	endfunction

	// Builds round(sin(pi/2 * k / depth) * 2^16) with a Q30 Taylor series.
	function automatic sine_rom_t build_sine_rom();
		sine_rom_t rom;
		longint x;
		longint x2;
		longint term;
		longint sum;
		longint v;
		for (int k = 0; k <= SINE_DEPTH; k++) begin
			// The table depth is a power of two, so the scaling is a shift.
			x = (PI_HALF_Q30 * longint'(k)) >>> SINE_IDX_W;
			x2 = (x * x) >>> 30;
			term = x;
			sum = x;
			for (int n = 1; n <= 10; n++) begin
				term = long_div((term * x2) >>> 30, longint'((2 * n) * (2 * n + 1)));
				if (n % 2 == 1) begin
					sum = sum - term;
				end else begin
					sum = sum + term;
				end
			end
			if (sum < 0) begin
				sum = 0;
			end
			v = (sum + 8192) >>> 14;
			if (v > longint'(ONE_Q16)) begin
				v = longint'(ONE_Q16);
			end
			rom[k] = v[SKEW_W-1:0];
		end
		return rom;
	endfunction

	localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

// ===== src/multi_waveform_oscillator_core.sv =====
// Top level of the phase-accumulator oscillator: sequencer, divider, multiplier and output register.
`timescale 1ns / 1ps

// Each transaction on the input channel produces one saturated Q3.20 sample computed from the
// phase held before the transaction, after which the 32-bit phase accumulator advances by the
// signed phase step (it holds when bypass is set or the waveform code is unused). The core works
// on one item at a time and stalls its input while busy. An item steps through IDLE and OUT in
// bypass or for an unused code, IDLE, MUL, ADD and OUT for the square, IDLE, ROM, MUL, ADD and OUT
// for the sine (ROM is the registered read of the 1025-entry quarter-wave table) and IDLE, DIV, MUL,
// ADD and OUT for the triangle, where a restoring divider retires one quotient bit per cycle. A
// finished result waits in the output register, and the next item is accepted meanwhile; the
// core only holds a new result back while that register is still stalled. Configuration writes
// are always ready and must be issued only while the core is idle.
module multi_waveform_oscillator_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [31:0]                  phase_step,
	input  logic [16:0]                         skew,
	input  logic signed [23:0]                  operand_a,
	input  logic signed [23:0]                  operand_b,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [mwo_pkg::SAMPLE_BITS-1:0] sample,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [1:0]                          cfg_index,
	input  logic [1:0]                          cfg_data
);

	mwo_pkg::state_t state_q;
	mwo_pkg::state_t state_d;

	logic [1:0]       waveform_q;
	logic             scale_mode_q;
	logic             bypass_q;
	mwo_pkg::phase_t  phase_q;
	logic             out_valid_q;
	mwo_pkg::sample_t sample_q;

	mwo_pkg::phase_t   work_phase_q;
	logic signed [23:0] a_q;
	logic signed [23:0] b_q;
	logic              below_q;
	mwo_pkg::wave_t    rem_q;
	mwo_pkg::wave_t    div_q;
	mwo_pkg::div_lo_t  lo_q;
	mwo_pkg::div_lo_t  quo_q;
	mwo_pkg::div_cnt_t cnt_q;
	mwo_pkg::wave_t    rom_q;
	mwo_pkg::prod_t    prod_q;
	logic              shift17_q;
	mwo_pkg::sample_t  res_q;

	logic in_accept;
	logic out_free;
	logic silent;
	logic div_step;
	logic div_last;

	// Input-side decode, from the accumulator before the step.
	mwo_pkg::wave_t   skew_sat;
	logic [mwo_pkg::PHASE_BITS:0] den_in;
	logic             below_in;
	mwo_pkg::phase_t  num_in;
	mwo_pkg::wave_t   divisor_in;

	// Divider step.
	logic [mwo_pkg::SKEW_W:0] trial;
	logic [mwo_pkg::SKEW_W:0] diff;
	logic                     fits;

	// Sine table address.
	logic [1:0]          quad;
	mwo_pkg::sine_idx_t  sine_idx;
	mwo_pkg::sine_addr_t rom_addr;

	// Multiplier operands and final scaling.
	mwo_pkg::fact_t  sine_val;
	mwo_pkg::wave_t  u_val;
	mwo_pkg::fact_t  fact;
	mwo_pkg::mcand_t mcand;
	mwo_pkg::prod_t  prod_d;
	mwo_pkg::acc_t   rounded;
	mwo_pkg::acc_t   scaled;
	mwo_pkg::acc_t   total;
	mwo_pkg::sample_t sat_val;

	assign skew_sat   = (skew > 17'(mwo_pkg::ONE_Q16)) ? 17'(mwo_pkg::ONE_Q16) : skew;
	assign den_in     = {skew_sat, mwo_pkg::div_lo_t'(0)};
	assign below_in   = {1'b0, phase_q} < den_in;
	assign num_in     = below_in ? phase_q : phase_q - den_in[mwo_pkg::PHASE_BITS-1:0];
	assign divisor_in = below_in ? skew_sat : 17'(mwo_pkg::ONE_Q16) - skew_sat;
	assign silent     = bypass_q || (waveform_q > mwo_pkg::WAVE_SQUARE);

	assign trial = {rem_q, lo_q[mwo_pkg::DIV_STEPS-1]};
	assign diff  = trial - {1'b0, div_q};
	assign fits  = trial >= {1'b0, div_q};

	assign quad     = work_phase_q[mwo_pkg::PHASE_BITS-1 -: 2];
	assign sine_idx = work_phase_q[mwo_pkg::PHASE_BITS-3 -: mwo_pkg::SINE_IDX_W];
	// Falling quadrants read the table backwards.
	assign rom_addr = quad[0] ? mwo_pkg::sine_addr_t'(mwo_pkg::SINE_DEPTH) - {1'b0, sine_idx}
	                          : {1'b0, sine_idx};

	always_comb begin
		sine_val = $signed({2'b00, rom_q});
		if (quad[1]) begin
			sine_val = -sine_val;
		end
		if (waveform_q == mwo_pkg::WAVE_TRIANGLE) begin
			u_val = below_q ? {1'b0, quo_q} : 17'(mwo_pkg::ONE_Q16) - {1'b0, quo_q};
		end else begin
			u_val = below_q ? 17'd0 : 17'(mwo_pkg::ONE_Q16);
		end
		if (scale_mode_q == mwo_pkg::MODE_OFFSET_SCALE) begin
			mcand = {b_q[23], b_q};
			if (waveform_q == mwo_pkg::WAVE_SINE) begin
				fact = sine_val;
			end else begin
				fact = $signed({1'b0, u_val, 1'b0}) - 19'sd65536;
			end
		end else begin
			mcand = {b_q[23], b_q} - {a_q[23], a_q};
			if (waveform_q == mwo_pkg::WAVE_SINE) begin
				fact = sine_val + 19'sd65536;
			end else begin
				fact = $signed({2'b00, u_val});
			end
		end
		prod_d = fact * mcand;
	end

	always_comb begin
		rounded = {{2{prod_q[mwo_pkg::PROD_W-1]}}, prod_q}
		        + (shift17_q ? mwo_pkg::acc_t'(65536) : mwo_pkg::acc_t'(32768));
		scaled  = shift17_q ? (rounded >>> 17) : (rounded >>> 16);
		total   = scaled + mwo_pkg::acc_t'(a_q);
		if (total > mwo_pkg::SAT_HI) begin
			sat_val = mwo_pkg::SAT_HI[mwo_pkg::SAMPLE_BITS-1:0];
		end else if (total < mwo_pkg::SAT_LO) begin
			sat_val = mwo_pkg::SAT_LO[mwo_pkg::SAMPLE_BITS-1:0];
		end else begin
			sat_val = total[mwo_pkg::SAMPLE_BITS-1:0];
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			mwo_pkg::ST_IDLE: begin
				if (in_valid) begin
					if (silent) begin
						state_d = mwo_pkg::ST_OUT;
					end else if (waveform_q == mwo_pkg::WAVE_SINE) begin
						state_d = mwo_pkg::ST_ROM;
					end else if (waveform_q == mwo_pkg::WAVE_TRIANGLE) begin
						state_d = mwo_pkg::ST_DIV;
					end else begin
						state_d = mwo_pkg::ST_MUL;
					end
				end
			end
			mwo_pkg::ST_ROM: state_d = mwo_pkg::ST_MUL;
			mwo_pkg::ST_DIV: begin
				if (div_last) begin
					state_d = mwo_pkg::ST_MUL;
				end
			end
			mwo_pkg::ST_MUL: state_d = mwo_pkg::ST_ADD;
			mwo_pkg::ST_ADD: state_d = mwo_pkg::ST_OUT;
			mwo_pkg::ST_OUT: begin
				if (out_free) begin
					state_d = mwo_pkg::ST_IDLE;
				end
			end
			default: state_d = mwo_pkg::ST_IDLE;
		endcase
	end

	// Control outputs of the sequencer.
	always_comb begin
		in_stall = (state_q != mwo_pkg::ST_IDLE);
		in_accept = in_valid && !in_stall;
		out_free = !out_valid_q || !out_stall;
		div_step = (state_q == mwo_pkg::ST_DIV);
		div_last = div_step && (cnt_q == mwo_pkg::div_cnt_t'(mwo_pkg::DIV_STEPS - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= mwo_pkg::ST_IDLE;
			phase_q      <= '0;
			waveform_q   <= mwo_pkg::WAVE_SINE;
			scale_mode_q <= 1'b1;
			bypass_q     <= 1'b0;
			out_valid_q  <= 1'b0;
			cnt_q        <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) begin
				case (cfg_index)
					mwo_pkg::REG_WAVEFORM:   waveform_q <= cfg_data;
					mwo_pkg::REG_SCALE_MODE: scale_mode_q <= cfg_data[0];
					mwo_pkg::REG_BYPASS:     bypass_q <= cfg_data[0];
					default: ;
				endcase
			end
			if (in_accept && !silent) begin
				phase_q <= phase_q + mwo_pkg::phase_t'(phase_step);
			end
			if (in_accept) begin
				cnt_q <= '0;
			end else if (div_step) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (state_q == mwo_pkg::ST_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		rom_q <= mwo_pkg::SINE_ROM[rom_addr];
		if (in_accept) begin
			work_phase_q <= phase_q;
			a_q          <= operand_a;
			b_q          <= operand_b;
			below_q      <= below_in;
			rem_q        <= {1'b0, num_in[mwo_pkg::PHASE_BITS-1:mwo_pkg::DIV_STEPS]};
			lo_q         <= num_in[mwo_pkg::DIV_STEPS-1:0];
			div_q        <= divisor_in;
			quo_q        <= '0;
			res_q        <= '0;
		end
		if (div_step) begin
			rem_q <= fits ? diff[mwo_pkg::SKEW_W-1:0] : trial[mwo_pkg::SKEW_W-1:0];
			lo_q  <= {lo_q[mwo_pkg::DIV_STEPS-2:0], 1'b0};
			quo_q <= {quo_q[mwo_pkg::DIV_STEPS-2:0], fits};
		end
		if (state_q == mwo_pkg::ST_MUL) begin
			prod_q    <= prod_d;
			// The sine interpolation works on 65536 + s, which carries one more fraction bit.
			shift17_q <= (waveform_q == mwo_pkg::WAVE_SINE)
			          && (scale_mode_q != mwo_pkg::MODE_OFFSET_SCALE);
		end
		if (state_q == mwo_pkg::ST_ADD) begin
			res_q <= sat_val;
		end
		if (state_q == mwo_pkg::ST_OUT && out_free) begin
			sample_q <= res_q;
		end
	end

	assign out_valid = out_valid_q;
	assign sample    = sample_q;
	assign cfg_ready = 1'b1;

`ifndef SYNTHESIS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input not stalled after a transaction");

	a_phase_held_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != mwo_pkg::ST_IDLE |=> $stable(phase_q))
		else $error("phase accumulator moved while busy");

	a_div_remainder: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == mwo_pkg::ST_DIV |-> rem_q < div_q)
		else $error("divider remainder not below divisor");
`endif

endmodule
